// ===== design/ambs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ambs_pkg
// Shared widths, constants and controller/datapath interface types for the
// adaptive maximum binary-tree size selection unit.
// ----------------------------------------------------------------------------
package ambs_pkg;

    localparam int NUM_LAYERS_DEFAULT = 8;

    localparam int TL_W   = 3;
    localparam int AREA_W = 15;
    localparam int POC_W  = 32;
    localparam int SUM_W  = 48;
    localparam int CNT_W  = 32;
    localparam int LIM_W  = 16;
    localparam int SIZE_W = 8;
    localparam int CFG_W  = 16;
    localparam int CFG_IDX_W = 2;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 8;

    localparam logic CMD_ACCUMULATE = 1'b0;
    localparam logic CMD_DECIDE     = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_SMALL_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MID_LIMIT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CTU_SIZE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_BT_CAP  = 2'd3;

    localparam logic [LIM_W-1:0]  SMALL_LIMIT_RESET = 16'd225;
    localparam logic [LIM_W-1:0]  MID_LIMIT_RESET   = 16'd900;
    localparam logic [SIZE_W-1:0] SIZE_32  = 8'd32;
    localparam logic [SIZE_W-1:0] SIZE_64  = 8'd64;
    localparam logic [SIZE_W-1:0] SIZE_128 = 8'd128;

    typedef struct packed {
        logic latch_in;
        logic accumulate;
        logic irap_update;
        logic check_reset;
        logic load_layer;
        logic mul_small;
        logic mul_mid;
        logic emit;
    } ambs_cmd_t;

    typedef struct packed {
        logic command;
        logic is_irap;
        logic cnt_nonzero;
        logic out_free;
    } ambs_status_t;

endpackage

// ===== design/ambs_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ambs_ctrl
// Controller state machine that sequences one request through the datapath.
// ----------------------------------------------------------------------------
module ambs_ctrl
    import ambs_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  ambs_status_t sts,
    output ambs_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_ACC       = 3'd1;
    localparam logic [2:0] S_IRAP      = 3'd2;
    localparam logic [2:0] S_CHECK     = 3'd3;
    localparam logic [2:0] S_LOAD      = 3'd4;
    localparam logic [2:0] S_MUL_SMALL = 3'd5;
    localparam logic [2:0] S_MUL_MID   = 3'd6;
    localparam logic [2:0] S_EMIT      = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = aresetn;
                if (s_tvalid && aresetn) begin
                    cmd.latch_in = 1'b1;
                    if (sts.command == CMD_ACCUMULATE) begin
                        state_next = S_ACC;
                    end else if (sts.is_irap) begin
                        state_next = S_IRAP;
                    end else begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_ACC: begin
                cmd.accumulate = 1'b1;
                state_next     = S_IDLE;
            end
            S_IRAP: begin
                cmd.irap_update = 1'b1;
                state_next      = S_IDLE;
            end
            S_CHECK: begin
                cmd.check_reset = 1'b1;
                state_next      = S_LOAD;
            end
            S_LOAD: begin
                cmd.load_layer = 1'b1;
                state_next     = sts.cnt_nonzero ? S_MUL_SMALL : S_IDLE;
            end
            S_MUL_SMALL: begin
                cmd.mul_small = 1'b1;
                state_next    = S_MUL_MID;
            end
            S_MUL_MID: begin
                cmd.mul_mid = 1'b1;
                state_next  = S_EMIT;
            end
            S_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/ambs_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ambs_datapath
// Per-layer area sums and counts, configuration registers, the shared
// threshold multiplier and the output register.
// ----------------------------------------------------------------------------
module ambs_datapath
    import ambs_pkg::*;
#(
    parameter int NUM_LAYERS = NUM_LAYERS_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tuser,
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic                 m_tuser,
    output logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  ambs_cmd_t            cmd,
    output ambs_status_t         sts
);

    localparam int LAYER_W = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1;
    localparam int TOP_LAYER = NUM_LAYERS - 1;

    logic [TL_W-1:0]   in_tl;
    logic              in_irap;
    logic [AREA_W-1:0] in_area;
    logic [POC_W-1:0]  in_poc;

    assign in_tl   = s_tdata[TL_W-1:0];
    assign in_irap = s_tdata[TL_W];
    assign in_area = s_tdata[TL_W+AREA_W:TL_W+1];
    assign in_poc  = s_tdata[TL_W+AREA_W+POC_W:TL_W+AREA_W+1];

    logic [LIM_W-1:0]  small_limit_reg;
    logic [LIM_W-1:0]  mid_limit_reg;
    logic [SIZE_W-1:0] ctu_size_reg;
    logic [SIZE_W-1:0] max_bt_cap_reg;

    logic [LAYER_W-1:0] layer_reg;
    logic               irap_reg;
    logic [AREA_W-1:0]  area_reg;
    logic [POC_W-1:0]   poc_reg;

    logic [SUM_W-1:0] area_sum_reg [NUM_LAYERS];
    logic [CNT_W-1:0] block_count_reg [NUM_LAYERS];
    logic             reset_armed_reg;
    logic [POC_W-1:0] last_intra_poc_reg;

    logic [SUM_W-1:0] sum_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [SUM_W-1:0] prod_reg;
    logic             lt_small_reg;

    logic              m_tvalid_reg;
    logic [SIZE_W-1:0] m_size_reg;

    logic [LAYER_W-1:0] layer_sel;
    logic [SUM_W:0]     sum_add;
    logic [SUM_W-1:0]   sum_sat;
    logic [CNT_W-1:0]   cnt_sat;
    logic               poc_gt;
    logic               clear_all;
    logic [LIM_W-1:0]   mul_op;
    logic [SUM_W-1:0]   mul_prod;
    logic               lt_mid;
    logic [SIZE_W-1:0]  size_pick;
    logic [SIZE_W-1:0]  size_capped;

    assign layer_sel = (32'(in_tl) > 32'(TOP_LAYER)) ? LAYER_W'(TOP_LAYER) : LAYER_W'(in_tl);

    assign sum_add = {1'b0, area_sum_reg[layer_reg]} + (SUM_W+1)'(area_reg);
    assign sum_sat = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
    assign cnt_sat = (block_count_reg[layer_reg] == '1) ? block_count_reg[layer_reg]
                                                        : block_count_reg[layer_reg] + 1'b1;

    assign poc_gt = $signed(poc_reg) > $signed(last_intra_poc_reg);
    assign clear_all = (cmd.irap_update && reset_armed_reg)
                     || (cmd.check_reset && reset_armed_reg && poc_gt);

    assign mul_op   = cmd.mul_mid ? mid_limit_reg : small_limit_reg;
    assign mul_prod = SUM_W'(mul_op) * SUM_W'(cnt_reg);

    assign lt_mid = sum_reg < prod_reg;

    always_comb begin
        if (lt_small_reg || ctu_size_reg == SIZE_32) begin
            size_pick = SIZE_32;
        end else if (lt_mid || ctu_size_reg == SIZE_64) begin
            size_pick = SIZE_64;
        end else begin
            size_pick = SIZE_128;
        end
        size_capped = (size_pick > max_bt_cap_reg) ? max_bt_cap_reg : size_pick;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            small_limit_reg <= SMALL_LIMIT_RESET;
            mid_limit_reg   <= MID_LIMIT_RESET;
            ctu_size_reg    <= SIZE_128;
            max_bt_cap_reg  <= SIZE_128;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_SMALL_LIMIT: small_limit_reg <= cfg_data;
                REG_MID_LIMIT:   mid_limit_reg   <= cfg_data;
                REG_CTU_SIZE:    ctu_size_reg    <= cfg_data[SIZE_W-1:0];
                REG_MAX_BT_CAP:  max_bt_cap_reg  <= cfg_data[SIZE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            layer_reg <= layer_sel;
            irap_reg  <= in_irap;
            area_reg  <= in_area;
            poc_reg   <= in_poc;
        end
        if (cmd.load_layer) begin
            sum_reg <= area_sum_reg[layer_reg];
            cnt_reg <= block_count_reg[layer_reg];
        end
        if (cmd.mul_small || cmd.mul_mid) begin
            prod_reg <= mul_prod;
        end
        if (cmd.mul_mid) begin
            lt_small_reg <= sum_reg < prod_reg;
        end
        if (cmd.emit) begin
            m_size_reg <= size_capped;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_LAYERS; i++) begin
                area_sum_reg[i]    <= '0;
                block_count_reg[i] <= '0;
            end
            reset_armed_reg    <= 1'b0;
            last_intra_poc_reg <= '0;
        end else begin
            if (clear_all) begin
                for (int i = 0; i < NUM_LAYERS; i++) begin
                    area_sum_reg[i]    <= '0;
                    block_count_reg[i] <= '0;
                end
            end else if (cmd.accumulate && !irap_reg) begin
                area_sum_reg[layer_reg]    <= sum_sat;
                block_count_reg[layer_reg] <= cnt_sat;
            end else if (cmd.emit) begin
                area_sum_reg[layer_reg]    <= '0;
                block_count_reg[layer_reg] <= '0;
            end
            if (cmd.irap_update) begin
                last_intra_poc_reg <= poc_reg;
                reset_armed_reg    <= 1'b1;
            end else if (cmd.check_reset && reset_armed_reg && poc_gt) begin
                reset_armed_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = 1'b1;
    assign m_tdata  = m_size_reg;

    assign sts.command     = s_tuser;
    assign sts.is_irap     = in_irap;
    assign sts.cnt_nonzero = block_count_reg[layer_reg] != '0;
    assign sts.out_free    = !m_tvalid_reg || m_tready;

endmodule

// ===== design/adaptive_max_bt_size_select_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_max_bt_size_select_unit
// Per-layer coding-unit area statistics and the choice of the maximum inter
// binary-tree size for each slice.
// ----------------------------------------------------------------------------
// An accumulate request passes through the accumulate state, an IRAP decide through
// the IRAP-update state, a non-IRAP decide for an empty layer through check and load.
// Any other decide goes through check, load, both multiplies and emit, which waits for a
// free output register and presents the result on the master side; the shared threshold
// multiplier is used twice in sequence. Reset clears all layer sums, counts, the pending
// reset and the registers to their defaults; requests are accepted, one at a time, once it ends.
module adaptive_max_bt_size_select_unit
    import ambs_pkg::*;
#(
    parameter int NUM_LAYERS = NUM_LAYERS_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 s_tuser,   // command
    input  logic [S_TDATA_W-1:0] s_tdata,   // temporal_layer, is_irap, cu_area, poc
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic                 m_tuser,   // override_split
    output logic [M_TDATA_W-1:0] m_tdata,   // max_bt_size
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    ambs_cmd_t    cmd;
    ambs_status_t sts;

    ambs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ambs_datapath #(
        .NUM_LAYERS (NUM_LAYERS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
